// ===== rtl/cicd_pkg.sv =====
// Package for the cloud-in-cell charge deposit unit.
// Grid sizes, word types, status and register codes. No dependencies.
package cicd_pkg;

  localparam int unsigned GRID_X = 16;
  localparam int unsigned GRID_Y = 16;
  localparam int unsigned GRID_Z = 16;
  localparam int unsigned CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned XW     = $clog2(GRID_X);
  localparam int unsigned YW     = $clog2(GRID_Y);
  localparam int unsigned ZW     = $clog2(GRID_Z);

  typedef enum logic [1:0] {
    ST_DEPOSIT = 2'd0,
    ST_DROP    = 2'd1,
    ST_READ    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_X    = 3'd3,
    CFG_INV_Y    = 3'd4,
    CFG_INV_Z    = 3'd5,
    CFG_CHARGE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_RD2, S_MX, S_MY, S_MZ, S_MCHK,
    S_CXY, S_CZ, S_CQ, S_CWR, S_DONE
  } state_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [11:0] cell_index;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [47:0] density;
  } out_word_t;

endpackage

// ===== rtl/cicd_mul.sv =====
// Shared registered 33x33 signed multiplier for the charge deposit unit.
// No package dependencies.
module cicd_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// ===== rtl/cloud_in_cell_charge_deposit_unit.sv =====
// Cloud-in-cell charge deposit unit: top level with grid memory and sequencer.
// Uses cicd_pkg and cicd_mul.
//
// Usage: input words arrive on in_valid_i/in_word_i and are taken when
// in_stall_o is low. Mode 0 deposits one particle, mode 1 reads and clears
// one cell. Each word gives exactly one output word on out_valid_o/out_word_o,
// held until out_stall_i is low.
// Sequence: a read passes S_RD and S_RD2, which read and clear the cell; a
// dropped particle ends after the three axis maps and the drop check; a
// deposit then runs S_CXY, S_CZ, S_CQ and S_CWR for each of 8 corners, and
// every word ends by loading the output register. The single shared
// multiplier sets this order: three products per corner plus one per axis,
// one per cycle. The next word is taken once the output register loads.
// One word is in work at a time; in_stall_o is high while it is.
// Reset: after rst_ni rises the grid is cleared one cell per cycle,
// all CELLS (4096) cells, with in_stall_o high. Configuration writes are taken.
// A stalled output holds its word; the next input word may be accepted, and
// its result waits until the output register is free.
module cloud_in_cell_charge_deposit_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cicd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cicd_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import cicd_pkg::*;

  logic [31:0] org_x_q, org_y_q, org_z_q, inv_x_q, inv_y_q, inv_z_q, charge_q;

  state_e      state_q, state_d;
  in_word_t    in_q;
  logic [XW-1:0] cx_q, cx_d;
  logic [YW-1:0] cy_q, cy_d;
  logic [ZW-1:0] cz_q, cz_d;
  logic [15:0] fx_q, fx_d, fy_q, fy_d, fz_q, fz_d;
  logic        bad_q, bad_d;
  logic [2:0]  corner_q, corner_d;
  logic [16:0] wxy_q, wxy_d;
  logic [AW-1:0] clr_q, clr_d;
  out_word_t   res_q, res_d;
  out_word_t   out_q;
  logic        out_valid_q;

  logic [47:0] mem [CELLS];
  logic [47:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr, corner_addr;
  logic        wr_en;
  logic [47:0] wr_data;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic signed [32:0] dx, dy, dz;
  logic        ev_neg, ev_inz, ev_drop;
  logic [31:0] ev_lim;
  logic        load_out, accept, idx_ok;
  logic [16:0] wx_s, wy_s, wz_s, w_r;
  logic [32:0] rnd_a;
  logic signed [48:0] rnd_q, sum;
  logic [47:0] sat;

  cicd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign dx = {in_q.pos_x[31], in_q.pos_x} - {org_x_q[31], org_x_q};
  assign dy = {in_q.pos_y[31], in_q.pos_y} - {org_y_q[31], org_y_q};
  assign dz = {in_q.pos_z[31], in_q.pos_z} - {org_z_q[31], org_z_q};

  assign idx_ok = (32'(in_q.cell_index) < 32'(CELLS));

  assign wx_s = corner_q[0] ? {1'b0, fx_q} : 17'h10000 - {1'b0, fx_q};
  assign wy_s = corner_q[1] ? {1'b0, fy_q} : 17'h10000 - {1'b0, fy_q};
  assign wz_s = corner_q[2] ? {1'b0, fz_q} : 17'h10000 - {1'b0, fz_q};

  assign corner_addr = AW'(cx_q) + AW'(corner_q[0]) + AW'(GRID_X) *
                       (AW'(cy_q) + AW'(corner_q[1]) +
                        AW'(GRID_Y) * (AW'(cz_q) + AW'(corner_q[2])));

  assign rnd_a = mul_p[32:0] + 33'd32768;
  assign w_r   = rnd_a[32:16];
  assign rnd_q = mul_p[48:0] + 49'sd32768;
  assign sum   = {rd_q[47], rd_q} + {{16{rnd_q[48]}}, rnd_q[48:16]};
  always_comb begin
    case (sum[48:47])
      2'b01:   sat = {1'b0, {47{1'b1}}};
      2'b10:   sat = {1'b1, {47{1'b0}}};
      default: sat = sum[47:0];
    endcase
  end

  // axis check on the product of the previous cycle
  always_comb begin
    ev_neg = dx[32];
    ev_inz = (inv_x_q != '0);
    ev_lim = 32'(GRID_X - 1);
    case (state_q)
      S_MZ: begin
        ev_neg = dy[32];
        ev_inz = (inv_y_q != '0);
        ev_lim = 32'(GRID_Y - 1);
      end
      S_MCHK: begin
        ev_neg = dz[32];
        ev_inz = (inv_z_q != '0);
        ev_lim = 32'(GRID_Z - 1);
      end
      default: ;
    endcase
    ev_drop = (ev_neg && ev_inz) || (mul_p[63:32] >= ev_lim);
  end

  always_comb begin
    state_d  = state_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    fz_d     = fz_q;
    bad_d    = bad_q;
    corner_d = corner_q;
    wxy_d    = wxy_q;
    clr_d    = clr_q;
    res_d    = res_q;
    mul_a    = {1'b0, dx[31:0]};
    mul_b    = {1'b0, inv_x_q};
    rd_addr  = corner_addr;
    wr_en    = 1'b0;
    wr_addr  = corner_addr;
    wr_data  = sat;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(CELLS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          bad_d    = 1'b0;
          corner_d = '0;
          state_d  = in_word_i.mode ? S_RD : S_MX;
        end
      end
      S_RD: begin
        rd_addr = AW'(in_q.cell_index);
        state_d = S_RD2;
      end
      S_RD2: begin
        wr_addr = AW'(in_q.cell_index);
        wr_data = '0;
        wr_en   = idx_ok;
        res_d.status  = ST_READ;
        res_d.density = idx_ok ? rd_q : '0;
        state_d = S_DONE;
      end
      S_MX: state_d = S_MY;
      S_MY: begin
        mul_a = {1'b0, dy[31:0]};
        mul_b = {1'b0, inv_y_q};
        cx_d  = mul_p[32 +: XW];
        fx_d  = mul_p[31:16];
        bad_d = ev_drop;
        state_d = S_MZ;
      end
      S_MZ: begin
        mul_a = {1'b0, dz[31:0]};
        mul_b = {1'b0, inv_z_q};
        cy_d  = mul_p[32 +: YW];
        fy_d  = mul_p[31:16];
        bad_d = bad_q || ev_drop;
        state_d = S_MCHK;
      end
      S_MCHK: begin
        cz_d = mul_p[32 +: ZW];
        fz_d = mul_p[31:16];
        if (bad_q || ev_drop) begin
          res_d.status  = ST_DROP;
          res_d.density = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_CXY;
        end
      end
      S_CXY: begin
        mul_a   = {16'b0, wx_s};
        mul_b   = {16'b0, wy_s};
        state_d = S_CZ;
      end
      S_CZ: begin
        mul_a   = {16'b0, w_r};
        mul_b   = {16'b0, wz_s};
        state_d = S_CQ;
      end
      S_CQ: begin
        wxy_d   = w_r;
        mul_a   = {charge_q[31], charge_q};
        mul_b   = {16'b0, w_r};
        state_d = S_CWR;
      end
      S_CWR: begin
        wr_en    = 1'b1;
        corner_d = corner_q + 1'b1;
        if (corner_q == 3'd7) begin
          res_d.status  = ST_DEPOSIT;
          res_d.density = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_CXY;
        end
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      corner_q    <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      org_z_q     <= '0;
      inv_x_q     <= 32'd65536;
      inv_y_q     <= 32'd65536;
      inv_z_q     <= 32'd65536;
      charge_q    <= 32'd65536;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      corner_q <= corner_d;
      bad_q    <= bad_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X: org_x_q  <= cfg_data_i;
          CFG_ORIGIN_Y: org_y_q  <= cfg_data_i;
          CFG_ORIGIN_Z: org_z_q  <= cfg_data_i;
          CFG_INV_X:    inv_x_q  <= cfg_data_i;
          CFG_INV_Y:    inv_y_q  <= cfg_data_i;
          CFG_INV_Z:    inv_z_q  <= cfg_data_i;
          CFG_CHARGE:   charge_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_word_i;
    if (load_out) out_q <= res_q;
  end

  always_ff @(posedge clk_i) begin
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cz_q  <= cz_d;
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    fz_q  <= fz_d;
    wxy_q <= wxy_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("input taken during grid clear");
  a_corner_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (corner_q != 3'd0) |-> (state_q == S_CXY || state_q == S_CZ ||
                            state_q == S_CQ || state_q == S_CWR))
    else $error("corner count outside deposit");
  a_density_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != ST_READ) |-> (out_word_o.density == '0))
    else $error("nonzero density on non-read word");
  a_wxy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CWR) |-> (wxy_q <= 17'h10000))
    else $error("corner weight out of range");
`endif

endmodule

// ===== bench/tb_cloud_in_cell_charge_deposit_unit.sv =====
// Testbench for the cloud-in-cell charge deposit unit: directed and random deposit/read words
// under several register settings, checked word by word against an in-bench grid model.
// Depends on cicd_pkg and cloud_in_cell_charge_deposit_unit.
`timescale 1ns / 100ps

module tb_cloud_in_cell_charge_deposit_unit;
  import cicd_pkg::*;

  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -64'sd140737488355328;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  longint      grid_sum [CELLS];
  longint      org [3];
  logic [31:0] inv [3];
  longint      charge;
  out_word_t   pending_q [$];
  int unsigned cycles, errors, n_dep, n_drop, n_read;
  bit          calm;

  cloud_in_cell_charge_deposit_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic bit map_axis(logic [31:0] pos, longint o, logic [31:0] r, int size,
                                  output int cell_no, output int frac);
    longint d;
    logic [63:0] u;
    cell_no = 0;
    frac = 0;
    if (r == 0) return 1'b1;
    d = longint'($signed(pos)) - o;
    if (d < 0) return 1'b0;
    u = 64'(d) * 64'(r);
    if (longint'(u[63:32]) + 1 >= size) return 1'b0;
    cell_no = int'(u[63:32]);
    frac = int'(u[31:16]);
    return 1'b1;
  endfunction

  function automatic out_word_t deposit_or_read(in_word_t w);
    out_word_t e;
    int cx, cy, cz, fx, fy, fz, idx;
    longint wx [2], wy [2], wz [2];
    longint wxy, wt, add, s;
    e = '{status: ST_DEPOSIT, density: '0};
    if (w.mode) begin
      e.status = ST_READ;
      idx = int'(w.cell_index);
      if (idx < CELLS) begin
        e.density = grid_sum[idx][47:0];
        grid_sum[idx] = 0;
      end
      n_read++;
      return e;
    end
    if (!map_axis(w.pos_x, org[0], inv[0], GRID_X, cx, fx) ||
        !map_axis(w.pos_y, org[1], inv[1], GRID_Y, cy, fy) ||
        !map_axis(w.pos_z, org[2], inv[2], GRID_Z, cz, fz)) begin
      e.status = ST_DROP;
      n_drop++;
      return e;
    end
    wx[0] = 65536 - fx; wx[1] = fx;
    wy[0] = 65536 - fy; wy[1] = fy;
    wz[0] = 65536 - fz; wz[1] = fz;
    for (int k = 0; k < 2; k++)
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 2; i++) begin
          wxy = (wx[i] * wy[j] + 32768) >> 16;
          wt = (wxy * wz[k] + 32768) >> 16;
          add = (charge * wt + 32768) >>> 16;
          idx = (cx + i) + GRID_X * ((cy + j) + GRID_Y * (cz + k));
          s = grid_sum[idx] + add;
          if (s > SUM_HI) s = SUM_HI;
          if (s < SUM_LO) s = SUM_LO;
          grid_sum[idx] = s;
        end
    n_dep++;
    return e;
  endfunction

  // output side: random stall and in-order compare
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status=%0d density=%h", $time, out_word.status,
                 out_word.density);
      end else begin
        e = pending_q.pop_front();
        if (out_word.status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_word.status);
        end
        if (out_word.density !== e.density) begin
          errors++;
          $display("%0t: density expected %h actual %h", $time, e.density, out_word.density);
        end
      end
    end
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 24);
  end

  task automatic send_word(in_word_t w);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 24);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    pending_q.push_back(deposit_or_read(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [31:0] v [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    for (int a = 0; a < 3; a++) begin
      org[a] = longint'($signed(v[CFG_ORIGIN_X + a]));
      inv[a] = v[CFG_INV_X + a];
    end
    charge = longint'($signed(v[CFG_CHARGE]));
  endtask

  function automatic in_word_t particle(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_word_t w;
    w = '{mode: 1'b0, pos_x: x, pos_y: y, pos_z: z, cell_index: 12'($urandom)};
    return w;
  endfunction

  function automatic in_word_t cell_read(int idx);
    in_word_t w;
    w = '{mode: 1'b1, pos_x: $urandom, pos_y: $urandom, pos_z: $urandom,
          cell_index: 12'(idx)};
    return w;
  endfunction

  // position mostly inside the grid for the current axis setting, a few just past it
  function automatic logic [31:0] near_grid(int a, int size);
    longint span, off;
    if (inv[a] == 0) return $urandom;
    span = (longint'(size - 1) << 32) / longint'(inv[a]);
    if (span > 64'sd1 << 30) span = 64'sd1 << 30;
    off = longint'($urandom_range(0, 32'(span + span / 16 + 1)));
    return 32'(org[a] + off);
  endfunction

  task automatic test_directed();
    send_word(particle(32'h0, 32'h0, 32'h0));
    send_word(particle(32'h0001_8000, 32'h0002_4000, 32'h0003_C000));
    send_word(particle(32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF));
    send_word(particle(32'h000F_0000, 32'h0, 32'h0));
    send_word(particle(32'h0, 32'h000F_0000, 32'h0));
    send_word(particle(32'h0, 32'h0, 32'h000F_0000));
    send_word(particle(32'hFFFF_FFFF, 32'h0, 32'h0));
    send_word(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_word(cell_read(0));
    send_word(cell_read(0));
    send_word(cell_read(1));
    send_word(cell_read(16));
    send_word(cell_read(256));
    send_word(cell_read(1 + 16 * (2 + 16 * 3)));
    send_word(cell_read(15 + 16 * (15 + 16 * 15)));
    send_word(cell_read(4095));
    drain();
  endtask

  task automatic test_odd_axes();
    logic [31:0] v [7];
    // zero reciprocal collapses an axis; all-ones reciprocal maps one LSB to almost a cell
    v = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
    load_regs(v);
    send_word(particle($urandom, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(particle($urandom, 32'h7FFF_FFFF, 32'h8000_0001));
    send_word(particle($urandom, 32'h7FFF_FFFE, 32'h8000_0000));
    send_word(cell_read(0));
    send_word(cell_read(1));
    send_word(cell_read(16));
    send_word(cell_read(17));
    drain();
  endtask

  task automatic test_random(int n, logic [31:0] v [7]);
    int r;
    load_regs(v);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 2);
      r = $urandom_range(99);
      if (r < 62)
        send_word(particle(near_grid(0, GRID_X), near_grid(1, GRID_Y), near_grid(2, GRID_Z)));
      else if (r < 72)
        send_word(particle($urandom, $urandom, $urandom));
      else if (r < 86)
        send_word(cell_read($urandom_range(0, 1023)));
      else
        send_word(cell_read($urandom_range(0, 4095)));
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    logic [31:0] v [7];
    for (int i = 0; i < CELLS; i++) grid_sum[i] = 0;
    org = '{0, 0, 0};
    inv = '{32'h1_0000, 32'h1_0000, 32'h1_0000};
    charge = 65536;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_odd_axes();
    v = '{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000};
    test_random(160, v);
    v = '{32'hFFFC_8000, 32'h0064_4000, 32'h8000_0000,
          32'h2_0000, 32'h0_8000, 32'h1_0000, 32'h8000_0000};
    test_random(160, v);
    v = '{32'h7FFF_0000, 32'h0001_2345, 32'hFFFF_FFFF,
          32'h1_0000, 32'h0, 32'h3_0000, 32'h7FFF_FFFF};
    test_random(160, v);
    v = '{32'h1234_5678, 32'hF000_0000, 32'h0,
          32'hFFFF_FFFF, 32'h1_8000, 32'h0_4000, 32'hFFFE_A000};
    test_random(160, v);
    $display("Covered %0d deposits, %0d dropped particles, %0d cell reads", n_dep, n_drop,
             n_read);
    $display("across six register settings, with random idling on both sides.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cicd_pkg.sv
rtl/cicd_mul.sv
rtl/cloud_in_cell_charge_deposit_unit.sv
bench/tb_cloud_in_cell_charge_deposit_unit.sv
